/* rtl/cipcm_pkg.sv */
package cipcm_pkg;

    localparam int MAX_PATH_BYTES = 8;
    localparam int PATH_LEN_W     = 4;

    localparam logic [7:0] SVC_OPEN      = 8'h54;
    localparam logic [7:0] SVC_OPEN_EX   = 8'h5B;
    localparam logic [7:0] SVC_CLOSE     = 8'h4E;
    localparam logic [7:0] SVC_READ      = 8'h4C;
    localparam logic [7:0] SVC_READ_FRAG = 8'h52;
    localparam logic [7:0] REPLY_FLAG    = 8'h80;
    localparam logic [7:0] ERR_UNSUPPORTED = 8'h08;
    localparam logic [7:0] OPEN_MIN_LEN  = 8'd48;
    localparam logic [7:0] CLOSE_BASE    = 8'd16;
    localparam logic [11:0] MASK_OPEN    = 12'h1FF;
    localparam logic [11:0] MASK_OPEN_EX = 12'hFFF;
    localparam logic [31:0] LFSR_SEED    = 32'hACE1ACE1;
    localparam logic [31:0] LFSR_TAPS    = 32'h80200003;

    localparam logic [1:0] REG_PATH = 2'd0;
    localparam logic [1:0] REG_LEN  = 2'd1;

    // reply kinds handed from the parser to the reply sequencer
    typedef enum logic [1:0] {
        KIND_ERR,
        KIND_OPEN,
        KIND_CLOSE,
        KIND_PASS
    } reply_kind_t;

    // snapshot of one finished request
    typedef struct packed {
        reply_kind_t kind;
        logic [7:0]  svc;
        logic [31:0] server_id;
        logic [31:0] client_id;
        logic [15:0] serial;
        logic [15:0] vendor;
        logic [31:0] client_serial;
        logic [31:0] o2t_interval;
        logic [31:0] t2o_interval;
    } reply_t;

    function automatic logic [31:0] lfsr_step(input logic [31:0] v);
        logic [31:0] r;
        r = v >> 1;
        if (v[0])
        begin
            r = r ^ LFSR_TAPS;
        end
        return r;
    endfunction

    function automatic logic [7:0] prefix_byte(input logic [2:0] p);
        logic [7:0] r;
        unique case (p)
            3'd1: r = 8'h02;
            3'd2: r = 8'h20;
            3'd3: r = 8'h06;
            3'd4: r = 8'h24;
            3'd5: r = 8'h01;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

/* rtl/cipcm_parser.sv */
module cipcm_parser (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_fire,
    input  logic [7:0]                            data_byte,
    input  logic                                  last_byte,
    input  logic [8*cipcm_pkg::MAX_PATH_BYTES-1:0] stored_path,
    input  logic [cipcm_pkg::PATH_LEN_W-1:0]      path_length,
    output logic                                  rep_valid,
    output cipcm_pkg::reply_t                     rep
);
    import cipcm_pkg::*;

    logic [7:0]  byte_count_reg, service_reg, pwc_reg;
    logic        prefix_ok_reg, path_ok_reg;
    logic [31:0] c_client_reg, c_cser_reg, c_o2ti_reg, c_t2oi_reg, c_o2tp_reg, c_t2op_reg;
    logic [15:0] c_ser_reg, c_ven_reg;
    logic [31:0] r_client_reg, r_cser_reg, r_o2ti_reg, r_t2oi_reg;
    logic [15:0] r_ser_reg, r_ven_reg;
    logic [31:0] srv_id_reg, lfsr_reg;
    logic [15:0] srv_seq_reg;
    logic [11:0] o2t_max_reg, t2o_max_reg;

    logic [7:0]  p, svc, bc_next, base, pstart, pend;
    logic        is_open, is_close, ext, pfx_ok, pth_ok, ok;
    logic [7:0]  pwc;
    logic [31:0] cl, cs, oi, ti, op, tp;
    logic [15:0] se, ve;
    logic [31:0] id1, id2;
    logic [11:0] mask;
    logic [2:0]  rel;
    logic [8:0]  need;

    // byte lane insert for little-endian captures
    function automatic logic [31:0] grab(input logic [31:0] f, input logic [7:0] pos,
                                         input logic [7:0] start, input logic [2:0] nb,
                                         input logic [7:0] d);
        logic [7:0]  off;
        logic [31:0] r;
        off = pos - start;
        r = f;
        if (pos >= start && off < {5'd0, nb})
        begin
            r = f | ({24'd0, d} << {off[1:0], 3'b000});
        end
        return r;
    endfunction

    always_comb
    begin
        p = byte_count_reg;
        svc = (p == 8'd0) ? data_byte : service_reg;
        pfx_ok = prefix_ok_reg;
        if (p != 8'd0 && p <= 8'd5 && data_byte != prefix_byte(p[2:0]))
        begin
            pfx_ok = 1'b0;
        end
        ext = (svc == SVC_OPEN_EX);
        is_open = (svc == SVC_OPEN) || ext;
        is_close = (svc == SVC_CLOSE);
        cl = c_client_reg; cs = c_cser_reg; oi = c_o2ti_reg; ti = c_t2oi_reg;
        op = c_o2tp_reg; tp = c_t2op_reg;
        se = c_ser_reg; ve = c_ven_reg;
        base = 8'd0;
        pstart = 8'd1;
        if (is_open)
        begin
            cl = grab(cl, p, 8'd12, 3'd4, data_byte);
            se = 16'(grab({16'd0, se}, p, 8'd16, 3'd2, data_byte));
            ve = 16'(grab({16'd0, ve}, p, 8'd18, 3'd2, data_byte));
            cs = grab(cs, p, 8'd20, 3'd4, data_byte);
            oi = grab(oi, p, 8'd28, 3'd4, data_byte);
            op = grab(op, p, 8'd32, ext ? 3'd4 : 3'd2, data_byte);
            ti = grab(ti, p, ext ? 8'd36 : 8'd34, 3'd4, data_byte);
            tp = grab(tp, p, ext ? 8'd40 : 8'd38, ext ? 3'd4 : 3'd2, data_byte);
            base = ext ? 8'd45 : 8'd41;
            pstart = base + 8'd1;
        end
        else if (is_close)
        begin
            se = 16'(grab({16'd0, se}, p, 8'd8, 3'd2, data_byte));
            ve = 16'(grab({16'd0, ve}, p, 8'd10, 3'd2, data_byte));
            cs = grab(cs, p, 8'd12, 3'd4, data_byte);
            base = CLOSE_BASE;
            pstart = CLOSE_BASE + 8'd2;
        end
        pwc = pwc_reg;
        pth_ok = path_ok_reg;
        pend = pstart + {4'd0, path_length};
        rel = 3'(p - pstart);
        if (is_open || is_close)
        begin
            if (p == base)
            begin
                pwc = data_byte;
            end
            else if (p >= pstart && p < pend && (p - pstart) < 8'(MAX_PATH_BYTES))
            begin
                if (data_byte != stored_path[{rel, 3'b000} +: 8])
                begin
                    pth_ok = 1'b0;
                end
            end
        end
        bc_next = (byte_count_reg == 8'd255) ? byte_count_reg : byte_count_reg + 8'd1;
        need = {1'b0, pstart} + {5'd0, path_length};
        ok = (is_open || is_close) && pfx_ok && pth_ok
             && ({1'b0, path_length} <= 5'(MAX_PATH_BYTES))
             && ({pwc, 1'b0} == {5'd0, path_length})
             && ({1'b0, bc_next} >= need);
        if (is_open && bc_next < OPEN_MIN_LEN)
        begin
            ok = 1'b0;
        end
        if (is_close && (se != r_ser_reg || ve != r_ven_reg || cs != r_cser_reg))
        begin
            ok = 1'b0;
        end
        id1 = lfsr_step(lfsr_reg);
        id2 = lfsr_step(id1);
        mask = ext ? MASK_OPEN_EX : MASK_OPEN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0; service_reg <= '0; pwc_reg <= '0;
            prefix_ok_reg <= 1'b1; path_ok_reg <= 1'b1;
            c_client_reg <= '0; c_cser_reg <= '0; c_o2ti_reg <= '0; c_t2oi_reg <= '0;
            c_o2tp_reg <= '0; c_t2op_reg <= '0; c_ser_reg <= '0; c_ven_reg <= '0;
            r_client_reg <= '0; r_cser_reg <= '0; r_o2ti_reg <= '0; r_t2oi_reg <= '0;
            r_ser_reg <= '0; r_ven_reg <= '0;
            srv_id_reg <= '0; srv_seq_reg <= '0; o2t_max_reg <= '0; t2o_max_reg <= '0;
            lfsr_reg <= LFSR_SEED;
            rep_valid <= 1'b0;
        end
        else
        begin
            rep_valid <= in_fire && last_byte;
            if (in_fire)
            begin
                if (last_byte)
                begin
                    byte_count_reg <= '0; service_reg <= '0; pwc_reg <= '0;
                    prefix_ok_reg <= 1'b1; path_ok_reg <= 1'b1;
                    c_client_reg <= '0; c_cser_reg <= '0; c_o2ti_reg <= '0;
                    c_t2oi_reg <= '0; c_o2tp_reg <= '0; c_t2op_reg <= '0;
                    c_ser_reg <= '0; c_ven_reg <= '0;
                    if (ok && is_open && svc != SVC_READ && svc != SVC_READ_FRAG)
                    begin
                        r_client_reg <= cl; r_ser_reg <= se; r_ven_reg <= ve;
                        r_cser_reg <= cs; r_o2ti_reg <= oi; r_t2oi_reg <= ti;
                        srv_id_reg <= id1; srv_seq_reg <= id2[15:0];
                        o2t_max_reg <= op[11:0] & mask;
                        t2o_max_reg <= tp[11:0] & mask;
                        lfsr_reg <= id2;
                    end
                end
                else
                begin
                    byte_count_reg <= bc_next; service_reg <= svc; pwc_reg <= pwc;
                    prefix_ok_reg <= pfx_ok; path_ok_reg <= pth_ok;
                    c_client_reg <= cl; c_cser_reg <= cs; c_o2ti_reg <= oi;
                    c_t2oi_reg <= ti; c_o2tp_reg <= op; c_t2op_reg <= tp;
                    c_ser_reg <= se; c_ven_reg <= ve;
                end
            end
        end
    end

    // reply snapshot, payload only
    always_ff @(posedge clk)
    begin
        if (in_fire && last_byte)
        begin
            rep.svc <= svc;
            if (svc == SVC_READ || svc == SVC_READ_FRAG)
            begin
                rep.kind <= KIND_PASS;
            end
            else if (!ok)
            begin
                rep.kind <= KIND_ERR;
            end
            else if (is_open)
            begin
                rep.kind <= KIND_OPEN;
            end
            else
            begin
                rep.kind <= KIND_CLOSE;
            end
            if (is_open)
            begin
                rep.server_id <= id1; rep.client_id <= cl; rep.serial <= se;
                rep.vendor <= ve; rep.client_serial <= cs;
                rep.o2t_interval <= oi; rep.t2o_interval <= ti;
            end
            else
            begin
                rep.server_id <= srv_id_reg; rep.client_id <= r_client_reg;
                rep.serial <= r_ser_reg; rep.vendor <= r_ven_reg;
                rep.client_serial <= r_cser_reg;
                rep.o2t_interval <= r_o2ti_reg; rep.t2o_interval <= r_t2oi_reg;
            end
        end
    end

    // values kept for a later reader; not on the reply path
    logic unused_keep;
    assign unused_keep = ^{srv_seq_reg, o2t_max_reg, t2o_max_reg};

endmodule

/* rtl/cipcm_reply.sv */
module cipcm_reply (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rep_valid,
    input  cipcm_pkg::reply_t rep,
    input  logic              resp_stall,
    output logic              busy,
    output logic              resp_valid,
    output logic [7:0]        resp_byte,
    output logic              resp_last,
    output logic              pass_on
);
    import cipcm_pkg::*;

    reply_t     cur_reg;
    logic [4:0] idx_reg;
    logic [4:0] len;
    logic [7:0] b;
    logic       fire;

    always_comb
    begin
        unique case (cur_reg.kind)
            KIND_PASS:  len = 5'd1;
            KIND_ERR:   len = 5'd4;
            KIND_CLOSE: len = 5'd14;
            default:    len = 5'd30;
        endcase
        b = 8'd0;
        if (idx_reg == 5'd0)
        begin
            b = (cur_reg.kind == KIND_PASS) ? cur_reg.svc : (cur_reg.svc | REPLY_FLAG);
        end
        else if (cur_reg.kind == KIND_ERR)
        begin
            b = (idx_reg == 5'd2) ? ERR_UNSUPPORTED : 8'd0;
        end
        else if (cur_reg.kind == KIND_CLOSE)
        begin
            if (idx_reg >= 5'd4 && idx_reg < 5'd6)
                b = cur_reg.serial[{idx_reg[0], 3'b000} +: 8];
            else if (idx_reg >= 5'd6 && idx_reg < 5'd8)
                b = cur_reg.vendor[{idx_reg[0], 3'b000} +: 8];
            else if (idx_reg >= 5'd8 && idx_reg < 5'd12)
                b = cur_reg.client_serial[{idx_reg[1:0], 3'b000} +: 8];
        end
        else if (cur_reg.kind == KIND_OPEN)
        begin
            if (idx_reg >= 5'd4 && idx_reg < 5'd8)
                b = cur_reg.server_id[{idx_reg[1:0], 3'b000} +: 8];
            else if (idx_reg >= 5'd8 && idx_reg < 5'd12)
                b = cur_reg.client_id[{idx_reg[1:0], 3'b000} +: 8];
            else if (idx_reg >= 5'd12 && idx_reg < 5'd14)
                b = cur_reg.serial[{idx_reg[0], 3'b000} +: 8];
            else if (idx_reg >= 5'd14 && idx_reg < 5'd16)
                b = cur_reg.vendor[{idx_reg[0], 3'b000} +: 8];
            else if (idx_reg >= 5'd16 && idx_reg < 5'd20)
                b = cur_reg.client_serial[{idx_reg[1:0], 3'b000} +: 8];
            else if (idx_reg >= 5'd20 && idx_reg < 5'd24)
                b = cur_reg.o2t_interval[{idx_reg[1:0], 3'b000} +: 8];
            else if (idx_reg >= 5'd24 && idx_reg < 5'd28)
                b = cur_reg.t2o_interval[{idx_reg[1:0], 3'b000} +: 8];
        end
        fire = resp_valid && !resp_stall;
    end

    assign resp_byte = b;
    assign resp_last = (idx_reg + 5'd1 == len);
    assign pass_on   = (cur_reg.kind == KIND_PASS);
    assign busy      = resp_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_valid <= 1'b0;
            idx_reg    <= '0;
        end
        else if (rep_valid)
        begin
            resp_valid <= 1'b1;
            idx_reg    <= '0;
        end
        else if (fire)
        begin
            if (resp_last)
            begin
                resp_valid <= 1'b0;
                idx_reg    <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rep_valid)
        begin
            cur_reg <= rep;
        end
    end

endmodule

/* rtl/cip_connection_manager_top.sv */
// CIP connection manager. Request bytes enter one word per cycle on data_byte/
// last_byte while in_stall is low; Forward Open (0x54), Forward Open Extended
// (0x5B) and Forward Close (0x4E) are parsed on the fly, each byte going through
// one register stage of field capture and path compare. The final request byte
// produces a reply of 30 (open), 14 (close) or 4 (error) words, or a single
// pass_on word for read services. The final byte sets the registered rep_valid,
// which in turn sets the registered out_valid that offers the first reply word.
// While a reply drains (one word per cycle when not stalled) input is stalled.
// stored_path sits at byte address 0 (64-bit), path_length at 8.
module cip_connection_manager_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  resp_byte,
    output logic        resp_last,
    output logic        pass_on
);
    import cipcm_pkg::*;

    logic [8*MAX_PATH_BYTES-1:0] stored_path_reg;
    logic [PATH_LEN_W-1:0]       path_length_reg;
    logic                        in_fire, rep_valid, busy;
    reply_t                      rep;
    logic [1:0]                  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3] ? REG_LEN : REG_PATH;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_path_reg <= '0;
            path_length_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (reg_idx == REG_PATH)
                stored_path_reg <= pwdata;
            else
                path_length_reg <= pwdata[PATH_LEN_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2:0] == 3'd0)
        begin
            if (reg_idx == REG_PATH)
                prdata = stored_path_reg;
            else
                prdata = {60'd0, path_length_reg};
        end
    end

    // hold input from the final byte until the reply is fully taken
    assign in_stall = busy || rep_valid;
    assign in_fire  = in_valid && !in_stall;

    cipcm_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .stored_path(stored_path_reg),
        .path_length(path_length_reg),
        .rep_valid  (rep_valid),
        .rep        (rep)
    );

    cipcm_reply u_reply (
        .clk        (clk),
        .rst_n      (rst_n),
        .rep_valid  (rep_valid),
        .rep        (rep),
        .resp_stall (out_stall),
        .busy       (busy),
        .resp_valid (out_valid),
        .resp_byte  (resp_byte),
        .resp_last  (resp_last),
        .pass_on    (pass_on)
    );

    a_no_accept_during_reply: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_fire) else $error("input taken during reply");
    a_reply_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && last_byte) |-> ##2 out_valid) else $error("no reply after last word");
    a_pass_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pass_on) |-> resp_last) else $error("pass_on reply not single");

endmodule
